// File: design/sea_pkg.sv
package sea_pkg;

  localparam int TGT_W      = 12;
  localparam int SPD_W      = 16;
  localparam int MAG_W      = SPD_W + 1;
  localparam int TIME_W     = 32;
  localparam int CH_W       = 4;
  localparam int PW_W       = 12;
  localparam int EST_W      = 14;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int EST_MAX       = 16383;
  localparam int SPEED_DIV_SH  = 10;
  localparam int SPEED_DIV_ODD = 5;
  localparam int SPEED_DIV     = SPEED_DIV_ODD << SPEED_DIV_SH;
  localparam int MOVES_SAT     = 65535;
  localparam int MTERM_W       = 17;
  localparam int PROD_W        = 27;
  localparam int SUM_W         = 28;

  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL = CFG_ADDR_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 2'd0,
    OP_MOVE    = 2'd1,
    OP_PROCESS = 2'd2,
    OP_NOP     = 2'd3
  } sea_op_t;

  typedef struct packed {
    logic capture;
    logic latch_delta;
    logic do_set;
    logic snap;
    logic start_fdiv;
    logic store_frac;
    logic start_mdiv;
    logic est_mul;
    logic est_sum;
    logic mul_lo;
    logic mul_hi;
    logic step_calc;
    logic step_apply;
    logic load_out;
  } sea_cmd_t;

  typedef struct packed {
    sea_op_t op;
    logic    gap_small;
    logic    interval_ok;
    logic    div_done;
  } sea_sts_t;

endpackage

// File: design/sea_div.sv
module sea_div #(
  parameter int N = 33,
  parameter int D = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient
);
  localparam int CW = $clog2(N + 1);

  logic         busy_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0] q_r;
  logic [D-1:0] rem_r;
  logic [D-1:0] dvs_r;
  logic [D:0]   trial;
  logic [D:0]   diff;
  logic         ge;

  assign trial = {rem_r, q_r[N-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(N);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[N-2:0], ge};
      rem_r <= ge ? diff[D-1:0] : trial[D-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// File: design/sea_dp.sv
module sea_dp #(
  parameter int POSITION_BITS        = 12,
  parameter int FRACTION_BITS        = 16,
  parameter int MIN_MOVE_INTERVAL_MS = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sea_pkg::sea_cmd_t                   cmd,
  output sea_pkg::sea_sts_t                   sts,
  input  logic [sea_pkg::OP_W-1:0]            in_op,
  input  logic [sea_pkg::IN_DATA_W-1:0]       in_data,
  input  logic [sea_pkg::CH_W-1:0]            channel,
  output logic [sea_pkg::OUT_DATA_W-1:0]      out_data
);
  import sea_pkg::*;

  localparam int PB     = POSITION_BITS;
  localparam int FB     = FRACTION_BITS;
  localparam int W      = PB + FB;
  localparam int TW     = (PB > TGT_W) ? PB : TGT_W;
  localparam int DIV_N  = PB + FB;
  localparam int DIV_D  = FB + 1;
  localparam int H      = (W + 1) / 2;
  localparam int MUL_W  = H + FB + 1;
  localparam int FULL_W = 2 * H + FB + 1;
  localparam int FONE   = 1 << FB;
  localparam int FMIN   = ((1 << FB) + 5) / 10;
  localparam int FX_W   = FB + 3;
  localparam int FX_K   = FX_W + 2;
  localparam int FX_RCP = ((1 << FX_K) + SPEED_DIV_ODD - 1) / SPEED_DIV_ODD;

  sea_op_t            op_r;
  logic [PB-1:0]      tgt_r;
  logic [SPD_W-1:0]   spd_r;
  logic [TIME_W-1:0]  now_r;
  logic [W-1:0]       pos_r;
  logic [PB-1:0]      dest_r;
  logic [FB:0]        frac_r;
  logic [TIME_W-1:0]  last_r;
  logic [W-1:0]       d_r;
  logic               up_r;
  logic [MUL_W-1:0]   acc_r;
  logic [MUL_W-1:0]   hi_r;
  logic [W-1:0]       step_r;
  logic [PB-1:0]      dist_r;
  logic [PROD_W-1:0]  prod_r;
  logic               res_cmd_r;
  logic               res_arr_r;
  logic [EST_W-1:0]   est_r;
  logic [FX_W-1:0]    fx_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [TW-1:0]      tgt_ext;
  logic [TW-1:0]      whole_ext;
  logic [PB-1:0]      whole;
  logic [PB-1:0]      gap;
  logic [W-1:0]       dfix;
  logic               up_c;
  logic [W-1:0]       diff_c;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   mag_c;
  logic [MAG_W+FB-1:0] mag_sh;
  logic [2*FX_W-1:0]  fx_prod;
  logic [FB:0]        frac_raw;
  logic               div_start;
  logic [DIV_N-1:0]   div_a;
  logic [DIV_D-1:0]   div_b;
  logic               div_busy;
  logic [DIV_N-1:0]   div_q;
  logic [FB:0]        frac_clamp;
  logic [H-1:0]       mul_a;
  logic [MUL_W-1:0]   mul_p;
  logic [FULL_W-1:0]  full;
  logic [MTERM_W-1:0] mterm;
  logic [SUM_W-1:0]   est_sum;
  logic [PW_W-1:0]    pw;
  logic [W-1:0]       pos_nxt;

  assign tgt_ext   = TW'(in_data[TGT_W-1:0]);
  assign whole     = pos_r[W-1:FB];
  assign whole_ext = TW'(whole);
  assign pw        = whole_ext[PW_W-1:0];
  assign gap       = (whole >= dest_r) ? whole - dest_r : dest_r - whole;
  assign dfix      = {dest_r, {FB{1'b0}}};
  assign up_c      = dfix >= pos_r;
  assign diff_c    = up_c ? dfix - pos_r : pos_r - dfix;
  assign mag       = spd_r[SPD_W-1] ? MAG_W'(17'h10000) - {1'b0, spd_r} : {1'b0, spd_r};

  assign mag_c    = (mag > MAG_W'(SPEED_DIV)) ? MAG_W'(SPEED_DIV) : mag;
  assign mag_sh   = {mag_c, {FB{1'b0}}} >> SPEED_DIV_SH;
  assign fx_prod  = (2*FX_W)'(fx_r) * (2*FX_W)'(FX_RCP);
  assign frac_raw = fx_prod[2*FX_W-1:FX_K];

  assign div_start = cmd.start_mdiv;
  assign div_a     = DIV_N'({diff_c[W-1:FB], {FB{1'b0}}});
  assign div_b     = DIV_D'(frac_r);

  sea_div #(
    .N(DIV_N),
    .D(DIV_D)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign frac_clamp = (frac_raw < (FB + 1)'(FMIN)) ? (FB + 1)'(FMIN) : frac_raw;

  assign mul_a = cmd.mul_hi ? H'(d_r[W-1:H]) : d_r[H-1:0];
  assign mul_p = MUL_W'(mul_a) * MUL_W'(frac_r);
  assign full  = {hi_r, {H{1'b0}}} + FULL_W'(acc_r);

  assign mterm   = (div_q >= DIV_N'(MOVES_SAT)) ? MTERM_W'(17'h10000)
                                                : MTERM_W'(div_q) + MTERM_W'(1);
  assign est_sum = SUM_W'(dist_r) + SUM_W'(prod_r >> 2);

  assign pos_nxt = up_r ? pos_r + step_r : pos_r - step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      dest_r <= '0;
      frac_r <= (FB + 1)'(FMIN);
      last_r <= '0;
    end else begin
      if (cmd.do_set) begin
        dest_r <= tgt_r;
        pos_r  <= {tgt_r, {FB{1'b0}}};
      end
      if (cmd.snap) begin
        pos_r <= dfix;
      end
      if (cmd.store_frac) begin
        frac_r <= frac_clamp;
        dest_r <= tgt_r;
      end
      if (cmd.step_apply) begin
        pos_r  <= pos_nxt;
        last_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= sea_op_t'(in_op);
      tgt_r     <= tgt_ext[PB-1:0];
      spd_r     <= in_data[TGT_W +: SPD_W];
      now_r     <= in_data[TGT_W + SPD_W +: TIME_W];
      res_cmd_r <= 1'b0;
      res_arr_r <= 1'b0;
      est_r     <= '0;
    end
    if (cmd.latch_delta) begin
      d_r  <= diff_c;
      up_r <= up_c;
    end
    if (cmd.start_fdiv) begin
      fx_r <= mag_sh[FX_W-1:0];
    end
    if (cmd.do_set || cmd.step_apply) begin
      res_cmd_r <= 1'b1;
    end
    if (cmd.snap) begin
      res_arr_r <= 1'b1;
    end
    if (cmd.start_mdiv) begin
      dist_r <= diff_c[W-1:FB];
    end
    if (cmd.est_mul) begin
      prod_r <= PROD_W'(mterm) * PROD_W'(MIN_MOVE_INTERVAL_MS);
    end
    if (cmd.est_sum) begin
      est_r <= (est_sum > SUM_W'(EST_MAX)) ? EST_W'(EST_MAX) : est_sum[EST_W-1:0];
    end
    if (cmd.mul_lo) begin
      acc_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      hi_r <= mul_p;
    end
    if (cmd.step_calc) begin
      step_r <= full[FB +: W];
    end
    if (cmd.load_out) begin
      out_data_r <= {est_r, res_arr_r, pw, channel, res_cmd_r};
    end
  end

  assign sts.op          = op_r;
  assign sts.gap_small   = gap < PB'(2);
  assign sts.interval_ok = (now_r - last_r) > TIME_W'(MIN_MOVE_INTERVAL_MS);
  assign sts.div_done    = !div_busy;
  assign out_data        = out_data_r;

endmodule

// File: design/sea_ctrl.sv
module sea_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sea_pkg::sea_sts_t sts,
  output sea_pkg::sea_cmd_t cmd
);
  import sea_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECODE = 12'b0000_0000_0010,
    S_FDIV   = 12'b0000_0000_0100,
    S_MSTART = 12'b0000_0000_1000,
    S_MDIV   = 12'b0000_0001_0000,
    S_EMUL   = 12'b0000_0010_0000,
    S_ESUM   = 12'b0000_0100_0000,
    S_MLO    = 12'b0000_1000_0000,
    S_MHI    = 12'b0001_0000_0000,
    S_SCALC  = 12'b0010_0000_0000,
    S_SAPPLY = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.latch_delta = 1'b1;
        unique case (sts.op)
          OP_SET: begin
            cmd.do_set = 1'b1;
            state_nxt  = S_EMIT;
          end
          OP_MOVE: begin
            cmd.start_fdiv = 1'b1;
            state_nxt      = S_FDIV;
          end
          OP_PROCESS: begin
            if (sts.gap_small) begin
              cmd.snap  = 1'b1;
              state_nxt = S_EMIT;
            end else if (sts.interval_ok) begin
              state_nxt = S_MLO;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_FDIV: begin
        cmd.store_frac = 1'b1;
        state_nxt      = S_MSTART;
      end
      S_MSTART: begin
        cmd.start_mdiv = 1'b1;
        state_nxt      = S_MDIV;
      end
      S_MDIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        cmd.est_mul = 1'b1;
        state_nxt   = S_ESUM;
      end
      S_ESUM: begin
        cmd.est_sum = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SCALC;
      end
      S_SCALC: begin
        cmd.step_calc = 1'b1;
        state_nxt     = S_SAPPLY;
      end
      S_SAPPLY: begin
        cmd.step_apply = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: design/servo_exponential_approach.sv
// Servo setpoint ramp with exponential approach. One result per input transfer; the
// operation code travels on in_tuser. A set transfer goes from decode straight to the
// output register, as does a process step when it waits or arrives; when it advances,
// the position step runs over two passes of one shared multiplier before it is applied.
// A move transfer waits on one bit-serial divider that counts the moves (the step
// fraction comes from a reciprocal multiply by the speed scale), then forms the estimate.
// The block holds one item at a time; the next transfer is taken as soon as the
// previous result sits in the output register.
module servo_exponential_approach #(
  parameter int POSITION_BITS        = 12,
  parameter int FRACTION_BITS        = 16,
  parameter int MIN_MOVE_INTERVAL_MS = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // target_position[11:0], speed_value[27:12], now_ms[59:28], zero[63:60]
  input  logic [sea_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation[1:0]
  input  logic [sea_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // command_valid[0], channel[4:1], pulse_width[16:5], arrived[17], estimated_ms[31:18]
  output logic [sea_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sea_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [sea_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [sea_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import sea_pkg::*;

  logic [CH_W-1:0] ch_r;
  sea_cmd_t        cmd;
  sea_sts_t        sts;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_CHANNEL) begin
      ch_r <= cfg_pwdata[CH_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == REG_CHANNEL) ? CFG_DATA_W'(ch_r) : '0;

  sea_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sea_dp #(
    .POSITION_BITS        (POSITION_BITS),
    .FRACTION_BITS        (FRACTION_BITS),
    .MIN_MOVE_INTERVAL_MS (MIN_MOVE_INTERVAL_MS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (in_tuser),
    .in_data  (in_tdata),
    .channel  (ch_r),
    .out_data (out_tdata)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sea_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int FRAC_ONE      = 1 << FRAC_BITS;
  localparam int FRAC_MIN      = (FRAC_ONE + 5) / 10;
  localparam int MOVE_INTERVAL = 1;
  localparam int ARRIVE_GAP    = 2;
  localparam int PHASE_ITEMS   = 210;

  typedef struct packed {
    logic [EST_W-1:0] est;
    logic             arrived;
    logic [PW_W-1:0]  pw;
    logic [CH_W-1:0]  ch;
    logic             valid;
  } servo_result_t;

  typedef struct {
    sea_op_t       op;
    logic [11:0]   tgt;
    logic [15:0]   spd;
    logic [31:0]   now;
    bit            fixed;
    servo_result_t res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  servo_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            errors = 0;

  logic [63:0] pos_q;
  logic [11:0] dest_q;
  logic [63:0] frac_q;
  logic [31:0] last_q;
  logic [3:0]  chan_q;

  logic [31:0] clock_ms = '0;
  int          burst_left = 0;
  int          rx_run = 0;
  int          rx_mode = 0;

  servo_exponential_approach DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic servo_result_t predict_servo(sea_op_t op, logic [11:0] tgt,
                                                  logic [15:0] spd, logic [31:0] now);
    logic [63:0]   mag, frac, dfix, diff, distance, moves, est, whole, gap, step;
    logic [31:0]   elapsed;
    servo_result_t r;
    r = '0;
    case (op)
      OP_SET: begin
        dest_q = tgt;
        pos_q = 64'(tgt) << FRAC_BITS;
        r.valid = 1'b1;
      end
      OP_MOVE: begin
        mag = spd[15] ? 64'h10000 - 64'(spd) : 64'(spd);
        frac = (mag << FRAC_BITS) / 64'(SPEED_DIV);
        if (frac > 64'(FRAC_ONE)) frac = 64'(FRAC_ONE);
        if (frac < 64'(FRAC_MIN)) frac = 64'(FRAC_MIN);
        frac_q = frac;
        dest_q = tgt;
        dfix = 64'(dest_q) << FRAC_BITS;
        diff = (dfix >= pos_q) ? dfix - pos_q : pos_q - dfix;
        distance = diff >> FRAC_BITS;
        moves = ((distance << FRAC_BITS) / frac) + 1;
        est = distance + (moves * 64'(MOVE_INTERVAL)) / 4;
        if (est > 64'(EST_MAX)) est = 64'(EST_MAX);
        r.est = est[EST_W-1:0];
      end
      OP_PROCESS: begin
        whole = pos_q >> FRAC_BITS;
        gap = (whole >= 64'(dest_q)) ? whole - 64'(dest_q) : 64'(dest_q) - whole;
        elapsed = now - last_q;
        dfix = 64'(dest_q) << FRAC_BITS;
        if (gap < 64'(ARRIVE_GAP)) begin
          pos_q = dfix;
          r.arrived = 1'b1;
        end else if (elapsed > 32'(MOVE_INTERVAL)) begin
          if (dfix >= pos_q) begin
            step = ((dfix - pos_q) * frac_q) >> FRAC_BITS;
            pos_q = pos_q + step;
          end else begin
            step = ((pos_q - dfix) * frac_q) >> FRAC_BITS;
            pos_q = pos_q - step;
          end
          last_q = now;
          r.valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.ch = chan_q;
    r.pw = pos_q[FRAC_BITS +: PW_W];
    return r;
  endfunction

  function automatic servo_result_t mk_res(logic valid, logic [3:0] ch, logic [11:0] pw,
                                           logic arrived, logic [13:0] est);
    servo_result_t r;
    r.valid = valid;
    r.ch = ch;
    r.pw = pw;
    r.arrived = arrived;
    r.est = est;
    return r;
  endfunction

  function automatic void add_row(sea_op_t op, logic [11:0] tgt, logic [15:0] spd,
                                  logic [31:0] now, bit fixed, servo_result_t res);
    stim_row_t row;
    row.op = op;
    row.tgt = tgt;
    row.spd = spd;
    row.now = now;
    row.fixed = fixed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [15:0] rand_speed();
    logic [15:0] picks[8];
    int          m;
    picks = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h1400, 16'hEC00, 16'h0200, 16'h0201};
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        m = $urandom_range(0, 5200);
        return $urandom_range(0, 1) ? 16'(0 - m) : 16'(m);
      end
      2: return picks[$urandom_range(0, 7)];
      default: return 16'($urandom_range(512, 5120));
    endcase
  endfunction

  task automatic send_item(sea_op_t op, logic [11:0] tgt, logic [15:0] spd, logic [31:0] now,
                           bit fixed, servo_result_t fixed_res);
    servo_result_t want;
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, now, spd, tgt};
    do @(posedge clk); while (!in_tready);
    want = predict_servo(op, tgt, spd, now);
    pending_results.push_back(fixed ? fixed_res : want);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_channel(logic [3:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_CHANNEL;
    cfg_pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    chan_q = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic run_random(int n);
    int      sent;
    int      pick;
    sea_op_t op;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      if (pick < 85) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_SET, 12'($urandom), 16'($urandom), $urandom, 1'b0, '0);
          sent++;
        end
        send_item(OP_MOVE, 12'($urandom), rand_speed(), $urandom, 1'b0, '0);
        sent++;
        repeat ($urandom_range(1, 30)) begin
          clock_ms = clock_ms + $urandom_range(0, 3);
          send_item(OP_PROCESS, 12'($urandom), 16'($urandom), clock_ms, 1'b0, '0);
          sent++;
        end
      end else begin
        op = sea_op_t'($urandom_range(0, 3));
        send_item(op, 12'($urandom), rand_speed(), $urandom, 1'b0, '0);
        if (op != OP_NOP) sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_run = $urandom_range(20, 300);
    end else begin
      rx_run--;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    servo_result_t got;
    servo_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, actual %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected valid=%0d ch=%0d pw=%0d arr=%0d est=%0d",
                   $time, want.valid, want.ch, want.pw, want.arrived, want.est);
          $display("%0t:          actual   valid=%0d ch=%0d pw=%0d arr=%0d est=%0d",
                   $time, got.valid, got.ch, got.pw, got.arrived, got.est);
        end
      end
    end
  end

  initial begin
    logic [3:0] channels[4];
    pos_q = '0;
    dest_q = '0;
    frac_q = 64'(FRAC_MIN);
    last_q = '0;
    chan_q = '0;
    channels = '{4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd9};

    add_row(OP_NOP,     12'hFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd5,         1, mk_res(0, 0, 0, 1, 0));
    add_row(OP_SET,     12'hFFF, 16'h0000, 32'd0,         1, mk_res(1, 0, 4095, 0, 0));
    add_row(OP_MOVE,    12'h000, 16'h1400, 32'd0,         1, mk_res(0, 0, 4095, 0, 5119));
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd0,         1, mk_res(0, 0, 4095, 0, 0));
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd1,         1, mk_res(0, 0, 4095, 0, 0));
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd2,         1, mk_res(1, 0, 0, 0, 0));
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd3,         1, mk_res(0, 0, 0, 1, 0));
    add_row(OP_MOVE,    12'hFFF, 16'h0000, 32'd0,         0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd100,       0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd101,       0, '0);
    add_row(OP_MOVE,    12'hFFF, 16'h8000, 32'd0,         0, '0);
    add_row(OP_MOVE,    12'hFFF, 16'h7FFF, 32'd0,         0, '0);
    add_row(OP_MOVE,    12'hFFF, 16'hFFFF, 32'd0,         0, '0);
    add_row(OP_MOVE,    12'hFFF, 16'h0200, 32'd0,         0, '0);
    add_row(OP_MOVE,    12'hFFF, 16'h0201, 32'd0,         0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'hFFFF_FFFF, 0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd1,         0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd2,         0, '0);
    add_row(OP_SET,     12'hAAA, 16'h0000, 32'd0,         0, '0);
    add_row(OP_MOVE,    12'hAAB, 16'h1400, 32'd0,         0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd10,        0, '0);
    add_row(OP_MOVE,    12'h555, 16'hEC00, 32'd0,         0, '0);
    add_row(OP_PROCESS, 12'h000, 16'h0000, 32'd20,        0, '0);
    add_row(OP_SET,     12'h555, 16'hFFFF, 32'hFFFF_FFFF, 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].tgt, directed_rows[i].spd,
                directed_rows[i].now, directed_rows[i].fixed, directed_rows[i].res);
    end
    clock_ms = 32'd1000;

    foreach (channels[p]) begin
      drain_results();
      write_channel(channels[p]);
      run_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/sea_pkg.sv
design/sea_div.sv
design/sea_dp.sv
design/sea_ctrl.sv
design/servo_exponential_approach.sv
bench/tb_top.sv
